// ===== rtl/core/ifs_split_pkg.sv =====
// Shared types and constants for the IFS field splitter.
package ifs_split_pkg;

  localparam int TEXT_DEPTH  = 4096;
  localparam int FIELD_DEPTH = 256;
  localparam int TEXT_W      = $clog2(TEXT_DEPTH + 1);
  localparam int FIELD_W     = $clog2(FIELD_DEPTH + 1);

  localparam int IFS_REGS    = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] IFS0_RESET = 64'h0000_0001_0000_0600;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IFS0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IFS1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IFS2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IFS3 = 3'd3;

  // input item kinds
  localparam logic [2:0] K_LITERAL = 3'd0;
  localparam logic [2:0] K_SPLIT   = 3'd1;
  localparam logic [2:0] K_QUOTE   = 3'd2;
  localparam logic [2:0] K_BOUND   = 3'd3;
  localparam logic [2:0] K_END     = 3'd4;

  // result kinds
  localparam logic [1:0] OK_TEXT   = 2'd0;
  localparam logic [1:0] OK_FIELD  = 2'd1;
  localparam logic [1:0] OK_TOTALS = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         text_byte;
    logic [TEXT_W-1:0]  text_pos;
    logic [FIELD_W-1:0] field_pos;
    logic [TEXT_W-1:0]  field_len;
    logic               overflow;
    logic               last;
  } result_t;

  // one request's worth of results: first always present, second optional
  typedef struct packed {
    result_t res_a;
    logic    has_b;
    result_t res_b;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

// ===== rtl/core/shell_ifs_field_splitter_top.sv =====
// Top level of the IFS field splitter: front, queue and back.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_kind, in_data_byte
//  out_    | output    | out_valid/out_stall| out_kind .. out_last
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle is accepted while the queue is not full; an end request
// that records a field gives two results, the field and then the totals.
// Results pass through the queue and the output register. Input stalls only
// when the four-entry queue is full. Reset is synchronous and clears counters,
// flags and the IFS set to space, tab and newline. cfg_ready is always high.
module shell_ifs_field_splitter_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         in_kind,
  input  logic [7:0]                         in_data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_kind,
  output logic [7:0]                         out_text_byte,
  output logic [ifs_split_pkg::TEXT_W-1:0]   out_text_pos,
  output logic [ifs_split_pkg::FIELD_W-1:0]  out_field_pos,
  output logic [ifs_split_pkg::TEXT_W-1:0]   out_field_len,
  output logic                               out_overflow,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ifs_split_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                        cfg_data
);

  ifs_split_pkg::push_t   push;
  ifs_split_pkg::entry_t  head;
  ifs_split_pkg::result_t res;
  logic                   q_full, head_valid, pop;

  assign cfg_ready = 1'b1;

  ifs_split_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .push         (push)
  );

  ifs_split_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ifs_split_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign out_kind      = res.kind;
  assign out_text_byte = res.text_byte;
  assign out_text_pos  = res.text_pos;
  assign out_field_pos = res.field_pos;
  assign out_field_len = res.field_len;
  assign out_overflow  = res.overflow;
  assign out_last      = res.last;

endmodule

// ===== rtl/core/ifs_split_front.sv =====
// Front end: accepts requests, classifies bytes against IFS, keeps split state.
module ifs_split_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [2:0]                             in_kind,
  input  logic [7:0]                             in_data_byte,
  input  logic                                   cfg_valid,
  input  logic [ifs_split_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                            cfg_data,
  input  logic                                   q_full,
  output ifs_split_pkg::push_t                   push
);

  localparam int TW = ifs_split_pkg::TEXT_W;
  localparam int FW = ifs_split_pkg::FIELD_W;
  localparam logic [TW-1:0] TEXT_FULL  = TW'(ifs_split_pkg::TEXT_DEPTH);
  localparam logic [FW-1:0] FIELD_FULL = FW'(ifs_split_pkg::FIELD_DEPTH);

  logic [63:0]   ifs_r [ifs_split_pkg::IFS_REGS];
  logic [TW-1:0] text_count_r, text_count_nxt;
  logic [FW-1:0] field_count_r, field_count_nxt;
  logic [TW-1:0] open_start_r, open_start_nxt;
  logic          field_open_r, field_open_nxt;
  logic          blank_pending_r, blank_pending_nxt;
  logic          overflowed_r, overflowed_nxt;

  logic                   accept;
  logic                   is_ifs, is_blank;
  logic                   do_store, do_open, close_req, is_end;
  logic                   close_ok, close_ovf, text_full;
  logic [TW-1:0]          close_start;
  ifs_split_pkg::result_t rec_byte, rec_close, rec_tot;
  ifs_split_pkg::entry_t  entry;
  logic                   has_a;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is_ifs   = ifs_r[in_data_byte[7:6]][in_data_byte[5:0]];
  assign is_blank = (in_data_byte == ifs_split_pkg::CH_SPACE) ||
                    (in_data_byte == ifs_split_pkg::CH_TAB) ||
                    (in_data_byte == ifs_split_pkg::CH_NL);

  assign text_full   = (text_count_r == TEXT_FULL);
  assign close_start = field_open_r ? open_start_r : text_count_r;
  assign close_ok    = close_req && (field_count_r != FIELD_FULL);
  assign close_ovf   = close_req && (field_count_r == FIELD_FULL);

  always_comb begin
    rec_byte           = '0;
    rec_byte.kind      = ifs_split_pkg::OK_TEXT;
    rec_byte.text_byte = in_data_byte;
    rec_byte.text_pos  = text_count_r;
    rec_byte.overflow  = overflowed_r;

    rec_close           = '0;
    rec_close.kind      = ifs_split_pkg::OK_FIELD;
    rec_close.text_pos  = close_start;
    rec_close.field_pos = field_count_r;
    rec_close.field_len = text_count_r - close_start;
    rec_close.overflow  = overflowed_r;

    rec_tot           = '0;
    rec_tot.kind      = ifs_split_pkg::OK_TOTALS;
    rec_tot.text_pos  = text_count_r;
    rec_tot.field_pos = field_count_r + FW'(close_ok);
    rec_tot.overflow  = overflowed_r | close_ovf;
    rec_tot.last      = 1'b1;
  end

  always_comb begin
    do_store          = 1'b0;
    do_open           = 1'b0;
    close_req         = 1'b0;
    is_end            = 1'b0;
    blank_pending_nxt = blank_pending_r;
    unique case (in_kind)
      ifs_split_pkg::K_LITERAL: begin
        do_store = 1'b1;
      end
      ifs_split_pkg::K_SPLIT: begin
        if (!is_ifs) begin
          do_store = 1'b1;
        end else if (is_blank) begin
          close_req = field_open_r;
          if (field_open_r) begin
            blank_pending_nxt = 1'b1;
          end
        end else begin
          close_req         = field_open_r || !blank_pending_r;
          blank_pending_nxt = 1'b0;
        end
      end
      ifs_split_pkg::K_QUOTE: begin
        do_open = 1'b1;
      end
      ifs_split_pkg::K_BOUND: begin
        close_req         = field_open_r;
        blank_pending_nxt = 1'b0;
      end
      ifs_split_pkg::K_END: begin
        close_req = field_open_r;
        is_end    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    text_count_nxt  = text_count_r;
    field_count_nxt = field_count_r;
    open_start_nxt  = open_start_r;
    field_open_nxt  = field_open_r;
    overflowed_nxt  = overflowed_r;
    has_a           = 1'b0;
    entry           = '0;

    if ((do_store || do_open) && !field_open_r) begin
      field_open_nxt = 1'b1;
      open_start_nxt = text_count_r;
    end
    if (do_store) begin
      if (text_full) begin
        overflowed_nxt = 1'b1;
      end else begin
        has_a          = 1'b1;
        entry.res_a    = rec_byte;
        text_count_nxt = text_count_r + TW'(1);
      end
    end
    if (close_req) begin
      field_open_nxt = 1'b0;
      if (close_ovf) begin
        overflowed_nxt = 1'b1;
      end else begin
        has_a           = 1'b1;
        entry.res_a     = rec_close;
        field_count_nxt = field_count_r + FW'(1);
      end
    end
    if (is_end) begin
      if (has_a) begin
        entry.has_b = 1'b1;
        entry.res_b = rec_tot;
      end else begin
        entry.res_a = rec_tot;
      end
      has_a           = 1'b1;
      text_count_nxt  = '0;
      field_count_nxt = '0;
      open_start_nxt  = '0;
      field_open_nxt  = 1'b0;
      overflowed_nxt  = 1'b0;
    end
  end

  assign push.valid = accept && has_a;
  assign push.entry = entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_count_r    <= '0;
      field_count_r   <= '0;
      open_start_r    <= '0;
      field_open_r    <= 1'b0;
      blank_pending_r <= 1'b0;
      overflowed_r    <= 1'b0;
    end else if (accept) begin
      text_count_r    <= text_count_nxt;
      field_count_r   <= field_count_nxt;
      open_start_r    <= open_start_nxt;
      field_open_r    <= field_open_nxt;
      blank_pending_r <= is_end ? 1'b0 : ((do_store || do_open) && !field_open_r) ?
                         1'b0 : blank_pending_nxt;
      overflowed_r    <= overflowed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ifs_r[0] <= ifs_split_pkg::IFS0_RESET;
      ifs_r[1] <= '0;
      ifs_r[2] <= '0;
      ifs_r[3] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ifs_split_pkg::REG_IFS0: ifs_r[0] <= cfg_data;
        ifs_split_pkg::REG_IFS1: ifs_r[1] <= cfg_data;
        ifs_split_pkg::REG_IFS2: ifs_r[2] <= cfg_data;
        ifs_split_pkg::REG_IFS3: ifs_r[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/ifs_split_queue.sv =====
// Short FIFO of result entries between front and back.
module ifs_split_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ifs_split_pkg::push_t  push,
  output logic                  full,
  output logic                  head_valid,
  output ifs_split_pkg::entry_t head,
  input  logic                  pop
);

  localparam int PW = ifs_split_pkg::QPTR_W;
  localparam int CW = ifs_split_pkg::QCNT_W;

  ifs_split_pkg::entry_t mem_r [ifs_split_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_pop;

  assign full       = (count_r == CW'(ifs_split_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_r + CW'(push.valid) - CW'(do_pop);
    end
  end

endmodule

// ===== rtl/core/ifs_split_back.sv =====
// Back end: unpacks queue entries into single results behind an output register.
module ifs_split_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  ifs_split_pkg::entry_t  head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ifs_split_pkg::result_t out_res
);

  logic                   sub_r;
  logic                   out_valid_r;
  ifs_split_pkg::result_t out_res_r;
  logic                   load;

  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign pop       = load && (sub_r || !head.has_b);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= sub_r ? head.res_b : head.res_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        sub_r       <= sub_r ? 1'b0 : head.has_b;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/ifs_split_checker.sv =====
// Port-level checker for the IFS field splitter, bound to the top level.
module ifs_split_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [1:0]                         out_kind,
  input logic [7:0]                         out_text_byte,
  input logic [ifs_split_pkg::TEXT_W-1:0]   out_text_pos,
  input logic [ifs_split_pkg::FIELD_W-1:0]  out_field_pos,
  input logic [ifs_split_pkg::TEXT_W-1:0]   out_field_len,
  input logic                               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
    $stable(out_text_pos) && $stable(out_text_byte))
    else $error("result changed while stalled");

  a_last_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind == ifs_split_pkg::OK_TOTALS)))
    else $error("last flag not on totals record");

  a_text_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ifs_split_pkg::OK_TEXT |->
    out_field_pos == '0 && out_field_len == '0 &&
    out_text_pos < ifs_split_pkg::TEXT_W'(ifs_split_pkg::TEXT_DEPTH))
    else $error("bad text byte record");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ifs_split_pkg::OK_FIELD |->
    out_field_pos < ifs_split_pkg::FIELD_W'(ifs_split_pkg::FIELD_DEPTH) &&
    out_text_byte == '0)
    else $error("bad field record");

endmodule

bind shell_ifs_field_splitter_top ifs_split_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_text_byte (out_text_byte),
  .out_text_pos  (out_text_pos),
  .out_field_pos (out_field_pos),
  .out_field_len (out_field_len),
  .out_last      (out_last)
);
